[src/multilevel_decimating_averager_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel decimating averager
// Concurrent checks sampled on the rising clock edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_DECIMATING_AVERAGER_ASSERT_SVH
`define MULTILEVEL_DECIMATING_AVERAGER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define MDA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define MDA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/mda_pkg.sv]
// ---------------------------------------------------------------------------
// Multilevel decimating averager package
// Field widths, parameter defaults and layout helpers of the level store.
// ---------------------------------------------------------------------------
package mda_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 2;
   localparam int SLOT_W     = 8;
   localparam int AVG_W      = 22;
   localparam int COUNT_W    = 12;
   localparam int RSP_DATA_W = 48;

   localparam int FIRST_LEVEL_SIZE_DEF = 256;
   localparam int NUM_LEVELS_DEF       = 4;
   localparam int MAX_VALUES_DEF       = 2048;

   // First store entry of a level: the levels lie one after another.
   function automatic int lvl_base(input int fls, input int lvl);
      int sum;
      sum = 0;
      for (int k = 0; k < lvl; k++) begin
         sum += fls >> k;
      end
      return sum;
   endfunction

endpackage

[src/multilevel_decimating_averager.sv]
// ---------------------------------------------------------------------------
// Multilevel decimating averager
// Pyramid of circular block-average histories kept in one level store.
// ---------------------------------------------------------------------------
// Each request carries one signed sample. Level i keeps FIRST_LEVEL_SIZE>>i
// slots, each the average of 4^i consecutive samples in fixed point with
// 2*(NUM_LEVELS-1) fraction bits. For every sample the block emits
// NUM_LEVELS results, level 0 first, the coarsest one marked with tlast.
// For each sample the level store, with one read port and one write port,
// does one read-modify-write per level, reads of the next level overlapping
// the write-back of the current one. The next request is taken in the cycle
// the last level's read is issued, so samples follow each other without a
// gap while the result side keeps up; a stalled result holds the whole
// read-modify-write chain. The store has 2*FIRST_LEVEL_SIZE entries and no
// clearing pass: each group's first sample overwrites its slot before any
// accumulation reads it.
module multilevel_decimating_averager #(
   parameter int FIRST_LEVEL_SIZE = mda_pkg::FIRST_LEVEL_SIZE_DEF,
   parameter int NUM_LEVELS       = mda_pkg::NUM_LEVELS_DEF,
   parameter int MAX_VALUES       = mda_pkg::MAX_VALUES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] sample
   input  logic [mda_pkg::SAMPLE_W-1:0]   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] slot, [29:8] average, [41:30] filled_count, [47:42] zero
   output logic [mda_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] level
   output logic [mda_pkg::LEVEL_W-1:0]    rsp_tuser,
   output logic                           rsp_tlast
);
   import mda_pkg::*;

   localparam int FRAC   = 2 * (NUM_LEVELS - 1);
   localparam int DEPTH  = 2 * FIRST_LEVEL_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(MAX_VALUES);
   localparam int CNT_W  = $clog2(MAX_VALUES + 1);
   localparam int WIN_W  = $clog2(FIRST_LEVEL_SIZE << (NUM_LEVELS - 1));
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SH_W   = $clog2(2 * NUM_LEVELS);
   localparam int PAD_W  = RSP_DATA_W - SLOT_W - AVG_W - COUNT_W;

   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);

   // Level store
   logic [AVG_W-1:0]  mem [DEPTH];
   logic [AVG_W-1:0]  rdata_ff;

   // Per-sample state
   logic              busy_ff, busy_in;
   logic [LVL_W-1:0]  rd_lvl_ff, rd_lvl_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WIN_W-1:0]  within_ff [NUM_LEVELS];
   logic [WIN_W-1:0]  within_in [NUM_LEVELS];

   // Update stage: one level waiting for its read data
   logic              c_vld_ff, c_vld_in;
   logic [LVL_W-1:0]  c_lvl_ff, c_lvl_in;
   logic [ADDR_W-1:0] c_addr_ff, c_addr_in;
   logic [SLOT_W-1:0] c_slot_ff, c_slot_in;
   logic              c_start_ff, c_start_in;
   logic [AVG_W-1:0]  c_scaled_ff, c_scaled_in;
   logic [COUNT_W-1:0] c_count_ff, c_count_in;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [AVG_W-1:0]  fwd_data_ff, fwd_data_in;

   // Result register
   logic              out_vld_ff, out_vld_in;
   logic [LEVEL_W-1:0] out_lvl_ff, out_lvl_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [AVG_W-1:0]  out_avg_ff, out_avg_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic              out_last_ff, out_last_in;

   // Per-level layout constants
   logic [31:0]       amount_tab [NUM_LEVELS];
   logic [31:0]       base_tab [NUM_LEVELS];

   logic              advance, issue, last_issue, accept, c_fire, pos_wrap;
   logic [AVG_W-1:0]  avg;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       slot_full, addr_full;
   logic [WIN_W-1:0]  group_idx;
   logic [POS_W-1:0]  group_mask;
   logic [AVG_W-1:0]  sample_ext;
   logic [SH_W-1:0]   sh_amt;
   logic [LVL_W:0]    two_lvl;

   // Handshake: the chain moves whenever the result register can take data.
   assign advance    = !out_vld_ff || rsp_tready;
   assign issue      = busy_ff && advance;
   assign last_issue = issue && (rd_lvl_ff == LAST_LVL);
   assign c_fire     = c_vld_ff && advance;
   // Take the next sample as soon as the current one's last read goes out.
   assign req_tready = !busy_ff || last_issue;
   assign accept     = req_tvalid && req_tready;
   assign pos_wrap   = (pos_ff == POS_W'(MAX_VALUES - 1));

   for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl
      localparam int SPAN = FIRST_LEVEL_SIZE << g;
      logic [WIN_W:0] within_inc;
      assign amount_tab[g] = 32'(FIRST_LEVEL_SIZE >> g);
      assign base_tab[g]   = 32'(lvl_base(FIRST_LEVEL_SIZE, g));
      assign within_inc    = (WIN_W + 1)'(within_ff[g]) + 1'b1;
      // Position within this level's span: advance with the write position,
      // wrap at the span and restart when the position wraps.
      assign within_in[g] = !last_issue ? within_ff[g] :
                            (pos_wrap || within_inc == (WIN_W + 1)'(SPAN)) ? '0 :
                            within_inc[WIN_W-1:0];
   end

   // Address and scaling of the level being read
   always_comb begin
      two_lvl    = {rd_lvl_ff, 1'b0};
      group_idx  = within_ff[rd_lvl_ff] >> two_lvl;
      slot_full  = amount_tab[rd_lvl_ff] - 32'd1 - 32'(group_idx);
      addr_full  = base_tab[rd_lvl_ff] + slot_full;
      rd_addr    = (addr_full >= 32'(DEPTH)) ? '0 : addr_full[ADDR_W-1:0];
      group_mask = (POS_W'(1) << two_lvl) - POS_W'(1);
      sample_ext = {{(AVG_W - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      sh_amt     = SH_W'(FRAC) - SH_W'(two_lvl);
   end

   // Accumulate, or overwrite on the first sample of a group
   always_comb begin
      if (c_start_ff) begin
         avg = c_scaled_ff;
      end else if (fwd_hit_ff) begin
         avg = fwd_data_ff + c_scaled_ff;
      end else begin
         avg = rdata_ff + c_scaled_ff;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rd_lvl_in    = rd_lvl_ff;
      sample_in    = sample_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      c_vld_in     = c_vld_ff;
      c_lvl_in     = c_lvl_ff;
      c_addr_in    = c_addr_ff;
      c_slot_in    = c_slot_ff;
      c_start_in   = c_start_ff;
      c_scaled_in  = c_scaled_ff;
      c_count_in   = c_count_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_data_in  = fwd_data_ff;
      out_vld_in   = out_vld_ff;
      out_lvl_in   = out_lvl_ff;
      out_slot_in  = out_slot_ff;
      out_avg_in   = out_avg_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;

      // Advance to the next level, and drop the sample after its last one.
      if (issue) begin
         rd_lvl_in = rd_lvl_ff + 1'b1;
      end
      if (last_issue) begin
         busy_in = 1'b0;
         pos_in  = pos_wrap ? '0 : pos_ff + 1'b1;
      end
      if (accept) begin
         busy_in   = 1'b1;
         rd_lvl_in = '0;
         sample_in = req_tdata;
         if (count_ff != CNT_W'(MAX_VALUES)) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (advance) begin
         c_vld_in = issue;
         if (issue) begin
            c_lvl_in    = rd_lvl_ff;
            c_addr_in   = rd_addr;
            c_slot_in   = slot_full[SLOT_W-1:0];
            c_start_in  = ((pos_ff & group_mask) == '0);
            c_scaled_in = sample_ext << sh_amt;
            c_count_in  = COUNT_W'(count_ff);
            // Forward a write-back that lands on the entry being read.
            fwd_hit_in  = c_fire && (c_addr_ff == rd_addr);
            fwd_data_in = avg;
         end
         out_vld_in = c_vld_ff;
         if (c_vld_ff) begin
            out_lvl_in   = LEVEL_W'(c_lvl_ff);
            out_slot_in  = c_slot_ff;
            out_avg_in   = avg;
            out_count_in = c_count_ff;
            out_last_in  = (c_lvl_ff == LAST_LVL);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         rd_lvl_ff  <= '0;
         pos_ff     <= '0;
         count_ff   <= '0;
         c_vld_ff   <= 1'b0;
         fwd_hit_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            within_ff[i] <= '0;
         end
      end else begin
         busy_ff    <= busy_in;
         rd_lvl_ff  <= rd_lvl_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         c_vld_ff   <= c_vld_in;
         fwd_hit_ff <= fwd_hit_in;
         out_vld_ff <= out_vld_in;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            within_ff[i] <= within_in[i];
         end
      end
      sample_ff    <= sample_in;
      c_lvl_ff     <= c_lvl_in;
      c_addr_ff    <= c_addr_in;
      c_slot_ff    <= c_slot_in;
      c_start_ff   <= c_start_in;
      c_scaled_ff  <= c_scaled_in;
      c_count_ff   <= c_count_in;
      fwd_data_ff  <= fwd_data_in;
      out_lvl_ff   <= out_lvl_in;
      out_slot_ff  <= out_slot_in;
      out_avg_ff   <= out_avg_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   // Level store: read on issue, write back when the update stage fires.
   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= mem[rd_addr];
      end
      if (c_fire) begin
         mem[c_addr_ff] <= avg;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_count_ff, out_avg_ff, out_slot_ff};
   assign rsp_tuser  = out_lvl_ff;
   assign rsp_tlast  = out_last_ff;

`include "multilevel_decimating_averager_assert.svh"

   `MDA_ASSERT_NOW(a_accept_when_free, accept, !busy_ff || last_issue, "request taken while busy")
   `MDA_ASSERT_NEXT(a_accept_starts, accept, busy_ff && rd_lvl_ff == '0, "sample did not start at level 0")
   `MDA_ASSERT_NOW(a_lvl_range, busy_ff, rd_lvl_ff <= LAST_LVL, "level counter out of range")
   `MDA_ASSERT_NOW(a_last_level, out_vld_ff && out_last_ff, out_lvl_ff == LEVEL_W'(LAST_LVL), "tlast on wrong level")

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// Multilevel decimating averager testbench
// Streams signed samples into the block and checks every level result
// against a local pyramid predictor, with random stalls on both channels.
// ---------------------------------------------------------------------------
// The predictor keeps its own write position, saturating sample count and
// one block sum per slot of every level, and queues NUM_LEVELS expected
// results per accepted request. A checker process pops one expectation per
// accepted result and compares level, slot, average, filled count, tlast
// and the zero padding of tdata.
// Tests, in order:
//   directed samples : field extremes, alternating bit patterns, a pause
//                      until every result is back, then a few more
//   random blocks    : coarse groups of random, full-scale positive,
//                      full-scale negative or near-zero samples
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mda_pkg::*;

   localparam int FLS  = FIRST_LEVEL_SIZE_DEF;
   localparam int NLV  = NUM_LEVELS_DEF;
   localparam int MAXV = MAX_VALUES_DEF;

   localparam int FRAC_BITS    = 2 * (NLV - 1);
   localparam int COARSE_GROUP = 1 << FRAC_BITS;   // samples per coarsest slot
   localparam int STORE_DEPTH  = 2 * FLS;
   localparam int POS_W        = $clog2(MAXV);

   // Field positions inside rsp_tdata, lowest field first.
   localparam int AVG_LSB   = SLOT_W;
   localparam int COUNT_LSB = AVG_LSB + AVG_W;
   localparam int PAD_LSB   = COUNT_LSB + COUNT_W;
   localparam int PAD_W     = RSP_DATA_W - PAD_LSB;

   localparam int RANDOM_ITEMS   = 130;
   localparam int SETTLE_CYCLES  = 24;     // a few samples' worth of latency
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   // Content of one coarse group of samples in the random parts.
   typedef enum logic [1:0] {
      BLOCK_RANDOM,
      BLOCK_TOP,
      BLOCK_BOTTOM,
      BLOCK_QUIET
   } block_mode_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [SLOT_W-1:0]  slot;
      logic [AVG_W-1:0]   average;
      logic [COUNT_W-1:0] filled_count;
      logic               last;
   } level_result_type;

   // -------------------------------------------------------------------------
   // DUT and its ports; every input holds a known value from time zero
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [LEVEL_W-1:0]    rsp_tuser;
   logic                  rsp_tlast;

   multilevel_decimating_averager #(
      .FIRST_LEVEL_SIZE(FLS),
      .NUM_LEVELS      (NLV),
      .MAX_VALUES      (MAXV)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor state and the store of expected level results
   // -------------------------------------------------------------------------
   logic [POS_W-1:0]   wr_pos     = '0;
   logic [COUNT_W-1:0] seen_count = '0;
   logic [AVG_W-1:0]   block_sum [STORE_DEPTH];   // never read before written
   level_result_type   pending_levels [$];

   block_mode_type sample_mode  = BLOCK_RANDOM;
   bit          req_idle_on  = 1'b1;
   bit          rsp_idle_on  = 1'b1;
   int          rsp_stall    = 0;
   int          mismatch_count = 0;
   int          idle_cycles  = 0;

   logic [RSP_DATA_W-1:0] seen_data;
   logic [LEVEL_W-1:0]    seen_level;
   logic                  seen_last;

   // Fold one sample into every level and queue the results it causes.
   // Level i covers 4^i samples per slot; slots run downward from the top of
   // the level as the position advances, and the first sample of a group
   // overwrites the slot instead of adding to it.
   function automatic void average_sample(input logic [SAMPLE_W-1:0] sample);
      int             pos;
      int             base;
      int             amount;
      int             span;
      int             shift;
      int             slot;
      logic [AVG_W-1:0] scaled;
      logic [AVG_W-1:0] avg;
      level_result_type res;
      pos  = wr_pos;
      base = 0;
      if (seen_count < MAXV) begin
         seen_count++;
      end
      for (int lvl = 0; lvl < NLV; lvl++) begin
         amount = FLS >> lvl;
         span   = FLS << lvl;
         shift  = 2 * lvl;
         slot   = amount - 1 - ((pos % span) >> shift);
         // sample weighted by 4^(levels-1-lvl): exact in the fixed point
         scaled = AVG_W'($signed(sample) * (1 << (FRAC_BITS - shift)));
         if ((pos & ((1 << shift) - 1)) == 0) begin
            avg = scaled;
         end else begin
            avg = block_sum[base + slot] + scaled;
         end
         block_sum[base + slot] = avg;
         res.level        = LEVEL_W'(lvl);
         res.slot         = SLOT_W'(slot);
         res.average      = avg;
         res.filled_count = seen_count;
         res.last         = (lvl == NLV - 1);
         pending_levels.push_back(res);
         base += amount;
      end
      wr_pos = (pos + 1 >= MAXV) ? '0 : POS_W'(pos + 1);
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int roll;
      if (!req_idle_on) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 93) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 8);
   endfunction

   // Pick a new content mode at the start of each coarse group, so that
   // whole groups of full-scale samples drive the averages to their extremes.
   function automatic logic [SAMPLE_W-1:0] next_sample();
      if ((wr_pos % COARSE_GROUP) == 0) begin
         sample_mode = block_mode_type'($urandom_range(3));
      end
      case (sample_mode)
         BLOCK_TOP: begin
            return {1'b0, {(SAMPLE_W - 1){1'b1}}};
         end
         BLOCK_BOTTOM: begin
            return {1'b1, {(SAMPLE_W - 1){1'b0}}};
         end
         BLOCK_QUIET: begin
            return SAMPLE_W'($urandom_range(15)) - SAMPLE_W'(8);
         end
         default: begin
            return SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   // Send one request: idle for a random gap, present it at the falling edge,
   // hold it until accepted, then predict. Return right after the accepting
   // edge with tvalid still high so the next request follows without a
   // second assignment in the same step.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      average_sample(sample);
   endtask

   // Drop tvalid and hold off until every expected result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // Turn idling on or off at random on each side now and then, giving stretches without gaps.
   task automatic shuffle_idling();
      req_idle_on = ($urandom_range(3) != 0);
      rsp_idle_on = ($urandom_range(3) != 0);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Extremes and bit patterns: the first sixteen fill one level-2 group, so
   // levels 1..3 each see an overwrite followed by accumulation, and every
   // sample bit takes both values. Then pause until drained and go on.
   task automatic test_directed_samples();
      logic [SAMPLE_W-1:0] patterns [20];
      patterns = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
                   16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h7FFF,
                   16'h7FFF, 16'h8000, 16'h8000, 16'h1234, 16'hEDCC,
                   16'h0F0F, 16'hF0F0, 16'h7FFF, 16'h8000, 16'h0000};
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < 16; i++) begin
         send_sample(patterns[i]);
      end
      wait_for_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (int i = 16; i < 20; i++) begin
         send_sample(patterns[i]);
      end
   endtask

   task automatic test_random_blocks();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 25 == 0) begin
            shuffle_idling();
         end
         send_sample(next_sample());
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: random backpressure, checking, watchdog
   // -------------------------------------------------------------------------
   // Mostly ready, short stalls, now and then a long one.
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  = rsp_stall - 1;
      end else if (rsp_idle_on && $urandom_range(99) < 30) begin
         rsp_tready <= 1'b0;
         rsp_stall  = ($urandom_range(99) < 90) ? $urandom_range(2, 0)
                                                : $urandom_range(35, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   task automatic check_level_result(input logic [RSP_DATA_W-1:0] data,
                                     input logic [LEVEL_W-1:0] level,
                                     input logic last);
      level_result_type want;
      if (pending_levels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: result with nothing expected, level %0d data %h",
                     $time, level, data);
         end
         return;
      end
      want = pending_levels.pop_front();
      compare_field("level", want.level, level);
      compare_field("slot", want.slot, data[0 +: SLOT_W]);
      compare_field("average", want.average, data[AVG_LSB +: AVG_W]);
      compare_field("filled_count", want.filled_count, data[COUNT_LSB +: COUNT_W]);
      compare_field("tlast", want.last, last);
      compare_field("tdata padding", '0, data[PAD_LSB +: PAD_W]);
   endtask

   // Capture at the rising edge, compare just after it: a prediction pushed
   // at the same edge is then always in the queue first.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_data  = rsp_tdata;
         seen_level = rsp_tuser;
         seen_last  = rsp_tlast;
         #1;
         check_level_result(seen_data, seen_level, seen_last);
      end
   end

   // End the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_samples();
      wait_for_results();
      test_random_blocks();

      // drain, then give a stray late result time to show up
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && pending_levels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/mda_pkg.sv
src/multilevel_decimating_averager.sv
test/testbench.sv
